[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared types, token kind codes, character codes and classification helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

   // Token kinds as they appear on the result channel.
   localparam logic [4:0] KIND_NUMBER   = 5'd0;
   localparam logic [4:0] KIND_STRING   = 5'd1;
   localparam logic [4:0] KIND_LPAREN   = 5'd2;
   localparam logic [4:0] KIND_RPAREN   = 5'd3;
   localparam logic [4:0] KIND_COMMA    = 5'd4;
   localparam logic [4:0] KIND_SEMI     = 5'd5;
   localparam logic [4:0] KIND_PLUS     = 5'd6;
   localparam logic [4:0] KIND_MINUS    = 5'd7;
   localparam logic [4:0] KIND_STAR     = 5'd8;
   localparam logic [4:0] KIND_SLASH    = 5'd9;
   localparam logic [4:0] KIND_ARROW    = 5'd10;
   localparam logic [4:0] KIND_EQUAL    = 5'd11;
   localparam logic [4:0] KIND_BANG     = 5'd12;
   localparam logic [4:0] KIND_AMP      = 5'd13;
   localparam logic [4:0] KIND_PIPE     = 5'd14;
   localparam logic [4:0] KIND_GT       = 5'd15;
   localparam logic [4:0] KIND_LT       = 5'd16;
   localparam logic [4:0] KIND_RBRACKET = 5'd17;
   localparam logic [4:0] KIND_LBRACKET = 5'd18;
   localparam logic [4:0] KIND_RBRACE   = 5'd19;
   localparam logic [4:0] KIND_LBRACE   = 5'd20;
   localparam logic [4:0] KIND_KEYWORD  = 5'd21;
   localparam logic [4:0] KIND_IDENT    = 5'd22;
   localparam logic [4:0] KIND_NONE     = 5'd0;

   // Character codes.
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_GT         = 8'h3E;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_O          = 8'h6F;
   localparam logic [7:0] CHAR_U          = 8'h75;
   localparam logic [7:0] CHAR_T          = 8'h74;
   localparam logic [7:0] CHAR_P          = 8'h70;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;

   // The keyword is six bytes long; the match counter reaches this on completion.
   localparam logic [2:0] KW_LEN = 3'd6;

   // Result queue between the lexer and the output stage.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_STRING,
      MODE_IDENT,
      MODE_EQUAL
   } mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_line;
      logic [15:0] token_column;
      logic [31:0] token_offset;
      logic [15:0] token_length;
      logic        run_last;
   } rsp_type;

   // Everything one input byte produces: one or two results.
   typedef struct packed {
      logic    has_second;
      rsp_type first;
      rsp_type second;
   } pair_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // Expected keyword byte at the given match position.
   function automatic logic [7:0] kw_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd1:    c = CHAR_U;
         3'd2:    c = CHAR_T;
         3'd3:    c = CHAR_P;
         3'd4:    c = CHAR_U;
         3'd5:    c = CHAR_T;
         default: c = CHAR_O;
      endcase
      return c;
   endfunction

   // Single-byte punctuation other than the equals sign; KIND_NONE otherwise.
   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h2C:   k = KIND_COMMA;
         8'h3B:   k = KIND_SEMI;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h21:   k = KIND_BANG;
         8'h26:   k = KIND_AMP;
         8'h7C:   k = KIND_PIPE;
         8'h3E:   k = KIND_GT;
         8'h3C:   k = KIND_LT;
         8'h5D:   k = KIND_RBRACKET;
         8'h5B:   k = KIND_LBRACKET;
         8'h7D:   k = KIND_RBRACE;
         8'h7B:   k = KIND_LBRACE;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

[rtl/stt_lexer.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer front end
// Classifies each byte, tracks position and builds the token records it causes.
// ----------------------------------------------------------------------------
module stt_lexer import stt_pkg::*; #(
   parameter int LINE_BITS   = 16,
   parameter int OFFSET_BITS = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req_data,
   output logic     push,
   output pair_type push_data
);

   mode_type                 mode_ff, mode_in;
   logic [2:0]               km_ff, km_in;
   logic [LINE_BITS-1:0]     start_line_ff, start_line_in;
   logic [LINE_BITS-1:0]     start_col_ff, start_col_in;
   logic [OFFSET_BITS-1:0]   start_off_ff, start_off_in;
   logic [LENGTH_BITS-1:0]   len_ff, len_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [LINE_BITS-1:0]     col_ff, col_in;
   logic [OFFSET_BITS-1:0]   off_ff, off_in;

   logic                     consumed, in_string;
   logic                     close_v, punct_v, flush_v;
   logic [4:0]               close_kind, punct_k, flush_kind;
   logic [LENGTH_BITS-1:0]   close_len;
   logic                     ident_ch;
   rsp_type                  close_rec, punct_rec, flush_rec;

   function automatic rsp_type make_rec(input logic [4:0] kind,
                                        input logic [LINE_BITS-1:0] ln,
                                        input logic [LINE_BITS-1:0] col,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [LENGTH_BITS-1:0] len);
      rsp_type     r;
      logic [63:0] ln_w, col_w, off_w, len_w;
      ln_w  = 64'(ln);
      col_w = 64'(col);
      off_w = 64'(off);
      len_w = 64'(len);
      r.token_kind   = kind;
      r.token_line   = ln_w[15:0];
      r.token_column = col_w[15:0];
      r.token_offset = off_w[31:0];
      r.token_length = len_w[15:0];
      r.run_last     = 1'b0;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         km_ff         <= '0;
         start_line_ff <= LINE_BITS'(1);
         start_col_ff  <= LINE_BITS'(1);
         start_off_ff  <= '0;
         len_ff        <= '0;
         line_ff       <= LINE_BITS'(1);
         col_ff        <= LINE_BITS'(1);
         off_ff        <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         km_ff         <= km_in;
         start_line_ff <= start_line_in;
         start_col_ff  <= start_col_in;
         start_off_ff  <= start_off_in;
         len_ff        <= len_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         off_ff        <= off_in;
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      km_in         = km_ff;
      start_line_in = start_line_ff;
      start_col_in  = start_col_ff;
      start_off_in  = start_off_ff;
      len_in        = len_ff;
      consumed      = 1'b0;
      in_string     = 1'b0;
      close_v       = 1'b0;
      close_kind    = KIND_NUMBER;
      close_len     = len_ff;
      punct_v       = 1'b0;
      punct_k       = punct_kind(req_data.in_char);
      flush_v       = 1'b0;
      flush_kind    = KIND_NUMBER;
      ident_ch      = is_alpha(req_data.in_char) || is_digit(req_data.in_char) ||
                      (req_data.in_char == CHAR_UNDERSCORE);

      // Continue or close the pending token.
      unique case (mode_ff)
         MODE_NUMBER: begin
            if (is_digit(req_data.in_char)) begin
               consumed = 1'b1;
               len_in   = (len_ff == '1) ? len_ff : len_ff + LENGTH_BITS'(1);
            end else begin
               close_v    = 1'b1;
               close_kind = KIND_NUMBER;
               mode_in    = MODE_IDLE;
               km_in      = '0;
            end
         end
         MODE_STRING: begin
            consumed  = 1'b1;
            in_string = 1'b1;
            if (req_data.in_char == CHAR_QUOTE) begin
               close_v    = 1'b1;
               close_kind = KIND_STRING;
               mode_in    = MODE_IDLE;
               km_in      = '0;
            end else begin
               len_in = (len_ff == '1) ? len_ff : len_ff + LENGTH_BITS'(1);
            end
         end
         MODE_IDENT: begin
            if (ident_ch) begin
               consumed = 1'b1;
               len_in   = (len_ff == '1) ? len_ff : len_ff + LENGTH_BITS'(1);
               if ((km_ff != '0) && (km_ff < KW_LEN) &&
                   (req_data.in_char == kw_char(km_ff))) begin
                  km_in = km_ff + 3'd1;
                  if (km_in == KW_LEN) begin
                     close_v    = 1'b1;
                     close_kind = KIND_KEYWORD;
                     close_len  = LENGTH_BITS'(KW_LEN);
                     len_in     = LENGTH_BITS'(KW_LEN);
                     mode_in    = MODE_IDLE;
                     km_in      = '0;
                  end
               end else begin
                  km_in = '0;
               end
            end else begin
               close_v    = 1'b1;
               close_kind = KIND_IDENT;
               mode_in    = MODE_IDLE;
               km_in      = '0;
            end
         end
         MODE_EQUAL: begin
            close_v = 1'b1;
            mode_in = MODE_IDLE;
            km_in   = '0;
            if (req_data.in_char == CHAR_GT) begin
               consumed   = 1'b1;
               close_kind = KIND_ARROW;
               close_len  = LENGTH_BITS'(2);
               len_in     = LENGTH_BITS'(2);
            end else begin
               close_kind = KIND_EQUAL;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // The byte on its own: start a token or emit punctuation.
      if (!consumed) begin
         if (is_digit(req_data.in_char)) begin
            start_line_in = line_ff;
            start_col_in  = col_ff;
            start_off_in  = off_ff;
            len_in        = LENGTH_BITS'(1);
            mode_in       = MODE_NUMBER;
         end else if (req_data.in_char == CHAR_QUOTE) begin
            start_line_in = line_ff;
            start_col_in  = col_ff;
            start_off_in  = (off_ff == '1) ? off_ff : off_ff + OFFSET_BITS'(1);
            len_in        = '0;
            mode_in       = MODE_STRING;
         end else if (req_data.in_char == CHAR_EQUAL) begin
            start_line_in = line_ff;
            start_col_in  = col_ff;
            start_off_in  = off_ff;
            len_in        = LENGTH_BITS'(1);
            mode_in       = MODE_EQUAL;
         end else if (ident_ch) begin
            start_line_in = line_ff;
            start_col_in  = col_ff;
            start_off_in  = off_ff;
            len_in        = LENGTH_BITS'(1);
            km_in         = (req_data.in_char == CHAR_O) ? 3'd1 : 3'd0;
            mode_in       = MODE_IDENT;
         end else begin
            punct_v = (punct_k != KIND_NONE);
         end
      end

      // Position counters; a newline inside a string only moves the column.
      if ((req_data.in_char == CHAR_NEWLINE) && !in_string) begin
         line_in = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
         col_in  = LINE_BITS'(1);
      end else begin
         line_in = line_ff;
         col_in  = (col_ff == '1) ? col_ff : col_ff + LINE_BITS'(1);
      end
      off_in = (off_ff == '1) ? off_ff : off_ff + OFFSET_BITS'(1);

      // Final byte: flush whatever is pending, then start a fresh source.
      if (req_data.in_last) begin
         flush_v = (mode_in != MODE_IDLE);
         unique case (mode_in)
            MODE_STRING: flush_kind = KIND_STRING;
            MODE_IDENT:  flush_kind = KIND_IDENT;
            MODE_EQUAL:  flush_kind = KIND_EQUAL;
            default:     flush_kind = KIND_NUMBER;
         endcase
      end

      close_rec = make_rec(close_kind, start_line_ff, start_col_ff, start_off_ff, close_len);
      punct_rec = make_rec(punct_k, line_ff, col_ff, off_ff, LENGTH_BITS'(1));
      flush_rec = make_rec(flush_kind, start_line_in, start_col_in, start_off_in, len_in);

      if (req_data.in_last) begin
         mode_in       = MODE_IDLE;
         km_in         = '0;
         start_line_in = LINE_BITS'(1);
         start_col_in  = LINE_BITS'(1);
         start_off_in  = '0;
         len_in        = '0;
         line_in       = LINE_BITS'(1);
         col_in        = LINE_BITS'(1);
         off_in        = '0;
      end

      // Order the results: closing token, then punctuation, then flush.
      push_data.has_second = 1'b0;
      push_data.first      = close_rec;
      push_data.second     = punct_v ? punct_rec : flush_rec;
      if (close_v) begin
         push_data.has_second = punct_v || flush_v;
      end else if (punct_v) begin
         push_data.first = punct_rec;
      end else begin
         push_data.first = flush_rec;
      end
      push_data.first.run_last  = !push_data.has_second;
      push_data.second.run_last = 1'b1;
      push = accept && (close_v || punct_v || flush_v);
   end

   a_km_only_in_ident: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDENT) |-> (km_ff == '0))
      else $error("keyword match held outside an identifier");

endmodule

[rtl/stt_queue.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer result queue
// Short queue of result pairs between the lexer and the output stage.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     valid,
   output pair_type head
);

   pair_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic                      do_pop;

   assign full   = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign valid  = (count_ff != '0);
   assign head   = entry_ff[rd_ptr_ff];
   assign do_pop = pop && valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + QUEUE_CNT_BITS'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - QUEUE_CNT_BITS'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("result queue count out of range");

endmodule

[rtl/stt_drain.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer output stage
// Takes result pairs from the queue and presents them one transfer at a time.
// ----------------------------------------------------------------------------
module stt_drain import stt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  pair_type q_head,
   output logic     q_pop,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output rsp_type  rsp_data
);

   rsp_type    rec0_ff, rec0_in;
   rsp_type    rec1_ff, rec1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop_ok;

   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_data  = rec0_ff;
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign q_pop     = q_valid && ((cnt_ff == 2'd0) || (pop_ok && (cnt_ff == 2'd1)));

   always_comb begin
      rec0_in = rec0_ff;
      rec1_in = rec1_ff;
      cnt_in  = cnt_ff;
      if (q_pop) begin
         rec0_in = q_head.first;
         rec1_in = q_head.second;
         cnt_in  = q_head.has_second ? 2'd2 : 2'd1;
      end else if (pop_ok) begin
         rec0_in = rec1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      rec0_ff <= rec0_in;
      rec1_ff <= rec1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_single_marks_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> rec0_ff.run_last)
      else $error("final result of a byte not marked");

   a_pair_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (!rec0_ff.run_last && rec1_ff.run_last))
      else $error("result pair marked out of order");

endmodule

[rtl/source_text_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: source bytes in, token records out, with position tracking.
// ----------------------------------------------------------------------------
// Source bytes enter on the req_ channel, which behaves as a queue: a byte is
// transferred at a rising edge with req_push high and req_full low. Token
// records leave on the rsp_ channel, also seen as a queue: the oldest record is
// on rsp_data while rsp_empty is low and is transferred when rsp_pop is high.
// One byte is taken in every cycle while the result queue has room. A byte can
// cause none, one or two records; run_last marks the final record of a byte.
// A record passes through the result queue and then the output stage register
// before it appears on rsp_data, where it can be transferred out.
// The output stage issues at most one record per cycle, so a byte that causes
// two records holds the result side for both transfers; that single output port
// sets the sustained rate when many bytes yield pairs.
// When the receiver stalls, up to four result pairs wait in the queue plus one
// pair in the output stage; after that req_full rises and input stalls.
// Reset clears the scanner to the start of a source (line 1, column 1, offset 0)
// and empties the queue. A byte with in_last set flushes any pending token and
// returns the scanner to the same starting point.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top import stt_pkg::*; #(
   parameter int LINE_BITS   = 16,
   parameter int OFFSET_BITS = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic     accept;
   logic     lex_push;
   pair_type lex_pair;
   logic     q_valid;
   logic     q_pop;
   pair_type q_head;

   // A byte is transferred whenever the queue can take the records it may cause.
   assign accept = req_push && !req_full;

   // Front end: classification, position counters and token assembly.
   stt_lexer #(
      .LINE_BITS  (LINE_BITS),
      .OFFSET_BITS(OFFSET_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_lexer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (lex_push),
      .push_data(lex_pair)
   );

   // Decoupling queue: lets the lexer run on while the receiver is stalled.
   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (lex_push),
      .push_data(lex_pair),
      .pop      (q_pop),
      .full     (req_full),
      .valid    (q_valid),
      .head     (q_head)
   );

   // Back end: splits each pair into single transfers from registers.
   stt_drain u_drain (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_pop  (rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_data (rsp_data)
   );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Streams short directed sources and random token soup through the lexer,
// predicts every token record in step and checks them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import stt_pkg::*;

   // An entry of the stimulus queue. A set pause flag holds the byte back until
   // every token predicted so far has been popped from the result side.
   typedef struct packed {
      logic    pause;
      req_type data;
   } source_item_type;

   localparam logic [47:0]   KEYWORD_TEXT = "output";
   localparam logic [8*17-1:0] PUNCT_TEXT = "(),;+-*/!&|><][}{";

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   source_item_type source_bytes[$];
   logic [7:0] draft[$];
   rsp_type    tokens_due[$];

   int  bytes_total   = 0;
   int  bytes_sent    = 0;
   int  bytes_taken   = 0;
   int  tokens_seen   = 0;
   int  sources_built = 0;
   int  error_count   = 0;
   logic req_moved    = 1'b0;
   logic calm;

   // Shadow of the lexer state, kept by the predictor below.
   mode_type    lex_mode;
   logic [2:0]  kw_pos;
   logic [15:0] tok_line, tok_col, tok_len;
   logic [31:0] tok_off;
   logic [15:0] cur_line, cur_col;
   logic [31:0] cur_off;
   rsp_type     step_out[2];
   int          step_n;

   source_text_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Neither side idles while this window of bytes is being sent, so that the
   // block also sees a long stretch at its full rate.
   assign calm = (bytes_sent >= 300) && (bytes_sent < 600);

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------
   function automatic logic digit_byte(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic letter_byte(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic [7:0] keyword_byte(input int idx);
      return KEYWORD_TEXT[8 * (5 - idx) +: 8];
   endfunction

   function automatic logic [15:0] inc16(input logic [15:0] v);
      return (v == '1) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] inc32(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic logic [4:0] punct_code(input logic [7:0] c);
      case (c)
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         ",":     return KIND_COMMA;
         ";":     return KIND_SEMI;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "!":     return KIND_BANG;
         "&":     return KIND_AMP;
         "|":     return KIND_PIPE;
         ">":     return KIND_GT;
         "<":     return KIND_LT;
         "]":     return KIND_RBRACKET;
         "[":     return KIND_LBRACKET;
         "}":     return KIND_RBRACE;
         "{":     return KIND_LBRACE;
         default: return KIND_NONE;
      endcase
   endfunction

   // Back to the start of a source: line 1, column 1, offset 0, nothing pending.
   function automatic void reset_lexer();
      lex_mode = MODE_IDLE;
      kw_pos   = '0;
      tok_line = 16'd1;
      tok_col  = 16'd1;
      tok_off  = '0;
      tok_len  = '0;
      cur_line = 16'd1;
      cur_col  = 16'd1;
      cur_off  = '0;
   endfunction

   function automatic void note_token(input logic [4:0] kind, input logic [15:0] line_no,
                                      input logic [15:0] col, input logic [31:0] off,
                                      input logic [15:0] len);
      step_out[step_n] = '{kind, line_no, col, off, len, 1'b0};
      step_n++;
   endfunction

   function automatic void close_token(input logic [4:0] kind);
      note_token(kind, tok_line, tok_col, tok_off, tok_len);
      lex_mode = MODE_IDLE;
      kw_pos   = '0;
   endfunction

   function automatic void start_token();
      tok_line = cur_line;
      tok_col  = cur_col;
      tok_off  = cur_off;
   endfunction

   // Works out the token records that one transferred byte causes and queues
   // them as expected results, the last of them marked with run_last.
   function automatic void lex_byte(input req_type r);
      logic [7:0] c;
      logic       taken;
      logic       in_text;
      logic [4:0] pk;
      c       = r.in_char;
      taken   = 1'b0;
      in_text = 1'b0;
      step_n  = 0;

      // First the byte continues or closes whatever token is pending.
      case (lex_mode)
         MODE_NUMBER: begin
            if (digit_byte(c)) begin
               tok_len = inc16(tok_len);
               taken   = 1'b1;
            end else begin
               close_token(KIND_NUMBER);
            end
         end
         MODE_STRING: begin
            in_text = 1'b1;
            taken   = 1'b1;
            if (c == CHAR_QUOTE) begin
               close_token(KIND_STRING);
            end else begin
               tok_len = inc16(tok_len);
            end
         end
         MODE_IDENT: begin
            if (letter_byte(c) || digit_byte(c) || c == CHAR_UNDERSCORE) begin
               taken   = 1'b1;
               tok_len = inc16(tok_len);
               // The keyword is only tracked from the first byte of a token.
               if (kw_pos >= 3'd1 && kw_pos <= 3'd5 && c == keyword_byte(kw_pos)) begin
                  kw_pos = kw_pos + 3'd1;
                  if (kw_pos == KW_LEN) begin
                     tok_len = 16'd6;
                     close_token(KIND_KEYWORD);
                  end
               end else begin
                  kw_pos = '0;
               end
            end else begin
               close_token(KIND_IDENT);
            end
         end
         MODE_EQUAL: begin
            if (c == CHAR_GT) begin
               tok_len = 16'd2;
               close_token(KIND_ARROW);
               taken = 1'b1;
            end else begin
               close_token(KIND_EQUAL);
            end
         end
         default: begin
         end
      endcase

      // Then a byte that nothing swallowed may begin a token of its own.
      if (!taken) begin
         if (digit_byte(c)) begin
            start_token();
            tok_len  = 16'd1;
            lex_mode = MODE_NUMBER;
         end else if (c == CHAR_QUOTE) begin
            start_token();
            tok_off  = inc32(cur_off);
            tok_len  = '0;
            lex_mode = MODE_STRING;
         end else if (c == CHAR_EQUAL) begin
            start_token();
            tok_len  = 16'd1;
            lex_mode = MODE_EQUAL;
         end else if (letter_byte(c) || c == CHAR_UNDERSCORE) begin
            start_token();
            tok_len  = 16'd1;
            kw_pos   = (c == CHAR_O) ? 3'd1 : 3'd0;
            lex_mode = MODE_IDENT;
         end else begin
            pk = punct_code(c);
            if (pk != KIND_NONE) begin
               note_token(pk, cur_line, cur_col, cur_off, 16'd1);
            end
         end
      end

      // A newline inside a string only moves the column on.
      if (c == CHAR_NEWLINE && !in_text) begin
         cur_line = inc16(cur_line);
         cur_col  = 16'd1;
      end else begin
         cur_col = inc16(cur_col);
      end
      cur_off = inc32(cur_off);

      if (r.in_last) begin
         case (lex_mode)
            MODE_NUMBER: close_token(KIND_NUMBER);
            MODE_STRING: close_token(KIND_STRING);
            MODE_IDENT:  close_token(KIND_IDENT);
            MODE_EQUAL:  close_token(KIND_EQUAL);
            default: begin
            end
         endcase
         reset_lexer();
      end

      if (step_n > 0) begin
         step_out[step_n - 1].run_last = 1'b1;
      end
      for (int i = 0; i < step_n; i++) begin
         tokens_due.insert(tokens_due.size(), step_out[i]);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
                                   tokens_seen, name, got, want));
      end
   endtask

   // Byte monitor: every transfer on the input side is fed to the predictor.
   always @(posedge clock) begin
      req_moved <= !reset && req_push && !req_full;
      if (!reset && req_push && !req_full) begin
         lex_byte(req_data);
         bytes_taken++;
      end
   end

   // Token monitor: each transfer on the result side is matched against the
   // oldest prediction still outstanding.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (tokens_due.size() == 0) begin
            report_mismatch($sformatf("token %0d (kind %0d) arrived with none expected",
                                      tokens_seen, rsp_data.token_kind));
         end else begin
            want = tokens_due.pop_front();
            check_field("kind",     32'(rsp_data.token_kind),   32'(want.token_kind));
            check_field("line",     32'(rsp_data.token_line),   32'(want.token_line));
            check_field("column",   32'(rsp_data.token_column), 32'(want.token_column));
            check_field("offset",   rsp_data.token_offset,      want.token_offset);
            check_field("length",   32'(rsp_data.token_length), 32'(want.token_length));
            check_field("run_last", 32'(rsp_data.run_last),     32'(want.run_last));
         end
         tokens_seen++;
      end
   end

   // -------------------------------------------------------------------------
   // Driver and receiver, both acting on the falling edge
   // -------------------------------------------------------------------------
   // A new byte is only presented once the current one has been transferred,
   // so req_push stays high across back-to-back transfers without a glitch.
   always @(negedge clock) begin
      source_item_type head;
      if (!reset && (!req_push || req_moved)) begin
         if (source_bytes.size() != 0 &&
             !(source_bytes[0].pause && tokens_due.size() != 0) &&
             (calm || $urandom_range(99) >= 16)) begin
            head = source_bytes.pop_front();
            req_data   <= head.data;
            req_push   <= 1'b1;
            bytes_sent <= bytes_sent + 1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_pop <= !reset && (calm || $urandom_range(99) >= 16);
   end

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------
   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_word_byte();
      return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
   endfunction

   // Any byte but a quote, with newlines made common.
   function automatic logic [7:0] rand_text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0 || b == CHAR_QUOTE) b = CHAR_NEWLINE;
      return b;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         draft.insert(draft.size(), s[i]);
      end
   endtask

   // Appends one mostly well-formed token to the source under construction.
   task automatic add_token();
      int n;
      case ($urandom_range(0, 11))
         0, 1: repeat ($urandom_range(1, 5)) draft.insert(draft.size(), rand_digit());
         2, 3: begin
            draft.insert(draft.size(), rand_letter());
            repeat ($urandom_range(0, 6)) draft.insert(draft.size(), rand_word_byte());
         end
         4: begin
            add_text("output");
            if ($urandom_range(0, 1) == 1) begin
               repeat ($urandom_range(1, 3)) draft.insert(draft.size(), rand_word_byte());
            end
         end
         5: begin
            // A keyword prefix that breaks off on an arbitrary byte.
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) draft.insert(draft.size(), keyword_byte(i));
            draft.insert(draft.size(), 8'($urandom_range(0, 255)));
         end
         6: begin
            draft.insert(draft.size(), CHAR_QUOTE);
            repeat ($urandom_range(0, 6)) draft.insert(draft.size(), rand_text_byte());
            draft.insert(draft.size(), CHAR_QUOTE);
         end
         7, 8: draft.insert(draft.size(), PUNCT_TEXT[8 * $urandom_range(0, 16) +: 8]);
         9: begin
            draft.insert(draft.size(), CHAR_EQUAL);
            if ($urandom_range(0, 1) == 1) draft.insert(draft.size(), CHAR_GT);
         end
         10: draft.insert(draft.size(), 8'($urandom_range(0, 255)));
         default: begin
            // A number running straight into letters.
            repeat ($urandom_range(1, 3)) draft.insert(draft.size(), rand_digit());
            repeat ($urandom_range(1, 3)) draft.insert(draft.size(), rand_letter());
         end
      endcase
   endtask

   task automatic add_gap();
      case ($urandom_range(0, 7))
         0, 1: begin
         end
         2, 3, 4: draft.insert(draft.size(), " ");
         5: draft.insert(draft.size(), CHAR_NEWLINE);
         6: draft.insert(draft.size(), 8'($urandom_range(9, 13)));
         default: add_text("  ");
      endcase
   endtask

   // Moves the draft into the stimulus queue; its final byte carries in_last.
   task automatic end_source(input logic pause);
      source_item_type it;
      foreach (draft[i]) begin
         it.pause        = pause && (i == 0);
         it.data.in_char = draft[i];
         it.data.in_last = (i == draft.size() - 1);
         source_bytes.insert(source_bytes.size(), it);
      end
      draft.delete();
      sources_built++;
   endtask

   initial begin
      int target;
      reset_lexer();

      // Directed sources. The first covers the keyword followed by letters,
      // the arrow, a number cut short by a letter, a lone equals sign closed
      // by punctuation (two records from one byte), the byte extremes, and an
      // unterminated string whose last byte is a newline.
      add_text("outputs=> 9z=(");
      draft.insert(draft.size(), 8'h00);
      draft.insert(draft.size(), 8'hFF);
      add_text("\"a\n");
      end_source(1'b0);
      // Pending number, partial keyword and lone equals flushed by in_last.
      add_text("7");
      end_source(1'b0);
      add_text("out");
      end_source(1'b0);
      add_text("=");
      end_source(1'b0);

      // Random sources of well-formed tokens with a little noise. The first
      // one waits for the directed results to drain completely.
      target = source_bytes.size() + 1300;
      while (source_bytes.size() < target) begin
         repeat ($urandom_range(1, 30)) begin
            add_token();
            add_gap();
         end
         case ($urandom_range(0, 7))
            0: begin
               draft.insert(draft.size(), CHAR_QUOTE);
               repeat ($urandom_range(0, 4)) draft.insert(draft.size(), rand_text_byte());
            end
            1, 2, 3: add_token();
            default: begin
            end
         endcase
         if (draft.size() == 0) draft.insert(draft.size(), " ");
         end_source(sources_built == 4);
      end

      bytes_total = source_bytes.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bytes_taken != bytes_total) @(negedge clock);
      while (tokens_due.size() != 0) @(negedge clock);
      // A little slack to catch any stray record after the last expected one.
      repeat (20) @(negedge clock);

      $display("Ran %0d bytes in %0d sources and compared %0d token records.",
               bytes_total, sources_built, tokens_seen);
      $display("Covered keywords, arrows, strings and flushes at end of source.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Safety net well beyond the slowest legal run.
   initial begin
      #(1_000_000);
      $display("Timeout with %0d token records still outstanding", tokens_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
rtl/stt_pkg.sv
rtl/stt_lexer.sv
rtl/stt_queue.sv
rtl/stt_drain.sv
rtl/source_text_tokenizer_top.sv
tb/tb_top.sv
